>>> src/bmprc_pkg.sv
// Shared types, constants and helper functions for the BMP pixel stream recolor unit.
// Used by the front end, the pixel queue, the back end and the top level.
package bmprc_pkg;

    // Largest image width or height in pixels.
    localparam int MAX_DIMENSION   = 4096;
    localparam int BYTES_PER_PIXEL = 3;

    // Field widths.
    localparam int C_DIM_W   = 13;
    localparam int C_ORG_W   = 12;
    localparam int C_COL_W   = 12;
    localparam int C_COORD_W = 13;
    localparam int C_COLOR_W = 24;
    localparam int C_BYTE_W  = 8;
    localparam int C_MODE_W  = 2;

    // Configuration port.
    localparam int C_CFG_IDX_W  = 3;
    localparam int C_CFG_DATA_W = 24;

    localparam logic [C_CFG_IDX_W-1:0] CFG_IMAGE_WIDTH   = 3'd0;
    localparam logic [C_CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT  = 3'd1;
    localparam logic [C_CFG_IDX_W-1:0] CFG_ORIGIN_X      = 3'd2;
    localparam logic [C_CFG_IDX_W-1:0] CFG_ORIGIN_Y      = 3'd3;
    localparam logic [C_CFG_IDX_W-1:0] CFG_RECOLOR_MODE  = 3'd4;
    localparam logic [C_CFG_IDX_W-1:0] CFG_MATCH_COLOR   = 3'd5;
    localparam logic [C_CFG_IDX_W-1:0] CFG_REPLACE_COLOR = 3'd6;

    localparam logic [C_DIM_W-1:0]   C_MAX_DIM = C_DIM_W'(MAX_DIMENSION);
    localparam logic [C_COLOR_W-1:0] C_BLACK   = '0;

    // Pixel queue depth.
    localparam int C_Q_DEPTH = 4;
    localparam int C_Q_PTR_W = $clog2(C_Q_DEPTH);
    localparam int C_Q_CNT_W = $clog2(C_Q_DEPTH + 1);

    typedef enum logic [C_MODE_W-1:0] {
        MODE_PASS    = 2'd0,
        MODE_REPLACE = 2'd1,
        MODE_KEEP    = 2'd2
    } t_mode;

    // Configuration as seen by the datapath, dimensions already clamped.
    typedef struct packed {
        logic [C_DIM_W-1:0]   width;
        logic [C_DIM_W-1:0]   height;
        logic [C_ORG_W-1:0]   origin_x;
        logic [C_ORG_W-1:0]   origin_y;
        logic [C_MODE_W-1:0]  mode;
        logic [C_COLOR_W-1:0] match_color;
        logic [C_COLOR_W-1:0] replace_color;
    } t_cfg;

    // One unpacked pixel before recoloring.
    typedef struct packed {
        logic [C_COORD_W-1:0] x;
        logic [C_COORD_W-1:0] y;
        logic [C_COLOR_W-1:0] color;
        logic                 last;
    } t_pixel;

    // Queue status seen by both ends.
    typedef struct packed {
        logic full;
        logic not_empty;
    } t_q_stat;

    // A dimension of zero counts as one; anything above the maximum saturates.
    function automatic logic [C_DIM_W-1:0] clamp_dim(input logic [C_DIM_W-1:0] v);
        logic [C_DIM_W-1:0] r;
        if (v == '0) begin
            r = C_DIM_W'(1);
        end else if (v > C_MAX_DIM) begin
            r = C_MAX_DIM;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

>>> src/bmprc_front.sv
// Front end: takes pixel array bytes, skips row padding, packs BGR triples and
// computes screen coordinates. Depends on bmprc_pkg.
module bmprc_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  bmprc_pkg::t_cfg               i_cfg,
    input  logic                          i_byte_valid,
    input  logic [bmprc_pkg::C_BYTE_W-1:0] i_byte,
    input  bmprc_pkg::t_q_stat            i_q_stat,
    output logic                          o_byte_stall,
    output logic                          o_push,
    output bmprc_pkg::t_pixel             o_pixel
);
    import bmprc_pkg::*;

    logic [1:0]           r_byte_phase, n_byte_phase;
    logic [15:0]          r_partial, n_partial;
    logic [C_COL_W-1:0]   r_column, n_column;
    logic [C_DIM_W-1:0]   r_rows_left, n_rows_left;
    logic [1:0]           r_pad_left, n_pad_left;

    logic                 take;
    logic                 new_image;
    logic [C_DIM_W-1:0]   rows_eff;
    logic [C_COL_W-1:0]   col_eff;
    logic [1:0]           phase_eff;
    logic [C_DIM_W-1:0]   col_next;
    logic                 row_end;

    assign o_byte_stall = i_q_stat.full;
    assign take         = i_byte_valid && !i_q_stat.full;

    // An idle unit starts a new image on the next pixel byte.
    assign new_image = (r_rows_left == '0);
    assign rows_eff  = new_image ? i_cfg.height : r_rows_left;
    assign col_eff   = new_image ? '0 : r_column;
    assign phase_eff = new_image ? 2'd0 : r_byte_phase;
    assign col_next  = {1'b0, col_eff} + C_DIM_W'(1);
    assign row_end   = (col_next >= i_cfg.width);

    always_comb begin
        n_byte_phase = r_byte_phase;
        n_partial    = r_partial;
        n_column     = r_column;
        n_rows_left  = r_rows_left;
        n_pad_left   = r_pad_left;
        o_push       = 1'b0;

        o_pixel.x     = {1'b0, i_cfg.origin_x} + {1'b0, col_eff};
        o_pixel.y     = {1'b0, i_cfg.origin_y} + rows_eff - C_COORD_W'(1);
        o_pixel.color = {i_byte, r_partial};
        o_pixel.last  = row_end && (rows_eff == C_DIM_W'(1));

        if (take) begin
            if (r_pad_left != 2'd0) begin
                n_pad_left = r_pad_left - 2'd1;
            end else begin
                n_rows_left = rows_eff;
                n_column    = col_eff;
                case (phase_eff)
                    2'd0: begin
                        n_partial[7:0] = i_byte;
                        n_byte_phase   = 2'd1;
                    end
                    2'd1: begin
                        n_partial[15:8] = i_byte;
                        n_byte_phase    = 2'd2;
                    end
                    default: begin
                        n_byte_phase = 2'd0;
                        o_push       = 1'b1;
                        if (row_end) begin
                            n_column    = '0;
                            n_pad_left  = i_cfg.width[1:0];
                            n_rows_left = rows_eff - C_DIM_W'(1);
                        end else begin
                            n_column = col_next[C_COL_W-1:0];
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_phase <= 2'd0;
            r_column     <= '0;
            r_rows_left  <= '0;
            r_pad_left   <= 2'd0;
        end else begin
            r_byte_phase <= n_byte_phase;
            r_column     <= n_column;
            r_rows_left  <= n_rows_left;
            r_pad_left   <= n_pad_left;
        end
    end

    always_ff @(posedge i_clk) begin
        r_partial <= n_partial;
    end

endmodule

>>> src/bmprc_queue.sv
// Short pixel queue between the front end and the back end.
// Depends on bmprc_pkg.
module bmprc_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  bmprc_pkg::t_pixel   i_pixel,
    input  logic                i_pop,
    output bmprc_pkg::t_pixel   o_pixel,
    output bmprc_pkg::t_q_stat  o_stat
);
    import bmprc_pkg::*;

    t_pixel               r_mem [C_Q_DEPTH];
    logic [C_Q_PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [C_Q_PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [C_Q_CNT_W-1:0] r_count, n_count;
    logic                 do_push;
    logic                 do_pop;

    assign o_stat.full      = (r_count == C_Q_CNT_W'(C_Q_DEPTH));
    assign o_stat.not_empty = (r_count != '0);
    assign o_pixel          = r_mem[r_rd_ptr];

    assign do_push = i_push && !o_stat.full;
    assign do_pop  = i_pop && o_stat.not_empty;

    always_comb begin
        n_wr_ptr = do_push ? r_wr_ptr + C_Q_PTR_W'(1) : r_wr_ptr;
        n_rd_ptr = do_pop  ? r_rd_ptr + C_Q_PTR_W'(1) : r_rd_ptr;
        n_count  = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + C_Q_CNT_W'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - C_Q_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_pixel;
        end
    end

endmodule

>>> src/bmprc_back.sv
// Back end: recolors the pixel at the queue head and holds it in the output
// register until the receiver takes it. Depends on bmprc_pkg.
module bmprc_back (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  bmprc_pkg::t_cfg                i_cfg,
    input  bmprc_pkg::t_q_stat             i_q_stat,
    input  bmprc_pkg::t_pixel              i_pixel,
    output logic                           o_pop,
    input  logic                           i_out_stall,
    output logic                           o_out_valid,
    output logic [bmprc_pkg::C_COORD_W-1:0] o_screen_x,
    output logic [bmprc_pkg::C_COORD_W-1:0] o_screen_y,
    output logic [bmprc_pkg::C_COLOR_W-1:0] o_pixel_color,
    output logic                           o_last_pixel
);
    import bmprc_pkg::*;

    logic                 r_valid;
    t_pixel               r_out;
    logic [C_COLOR_W-1:0] new_color;
    logic                 is_match;

    assign is_match = (i_pixel.color == i_cfg.match_color);

    always_comb begin
        unique case (i_cfg.mode)
            MODE_REPLACE: new_color = is_match ? i_cfg.replace_color : i_pixel.color;
            MODE_KEEP:    new_color = is_match ? i_pixel.color : C_BLACK;
            default:      new_color = i_pixel.color;
        endcase
    end

    // Load the output register whenever it is empty or being emptied.
    assign o_pop = i_q_stat.not_empty && (!r_valid || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out.x     <= i_pixel.x;
            r_out.y     <= i_pixel.y;
            r_out.color <= new_color;
            r_out.last  <= i_pixel.last;
        end
    end

    assign o_out_valid   = r_valid;
    assign o_screen_x    = r_out.x;
    assign o_screen_y    = r_out.y;
    assign o_pixel_color = r_out.color;
    assign o_last_pixel  = r_out.last;

endmodule

>>> src/bmp24_pixel_stream_recolor_unit.sv
// Top level of the BMP pixel stream recolor unit: configuration registers and
// the front end, pixel queue and back end. Depends on bmprc_pkg and its submodules.
//
// Usage:
//   The input channel (i_in_valid, o_in_stall, i_data_byte) carries the pixel
//   array of a 24-bit bottom-up BMP, one byte per request, row padding included.
//   Every third pixel byte yields one request on the output channel (o_out_valid,
//   i_out_stall) with screen coordinates, the recolored pixel and a last flag on
//   the final pixel of the image. Padding bytes produce nothing.
//   Throughput is one byte per cycle while o_in_stall is low. A pixel whose blue
//   byte, green byte and red byte have been taken is written into the queue and
//   then into the output register that the back end loads from the queue head.
//   The front end writes finished pixels into a four-entry queue; the back end
//   drains it into the output register. When the receiver stalls, the queue
//   fills and then o_in_stall rises, so no pixel is lost or repeated.
//   Configuration is written through i_cfg_we, i_cfg_index and i_cfg_data while
//   the unit is idle; width and height of zero count as one and values above the
//   maximum dimension saturate. Writes to an index past the register list are
//   ignored. Synchronous active-low reset restores the register defaults (width
//   and height one, all else zero), empties the queue and the output register,
//   and leaves the unit waiting for the first byte of a new image.
module bmp24_pixel_stream_recolor_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [bmprc_pkg::C_CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [bmprc_pkg::C_CFG_DATA_W-1:0] i_cfg_data,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [bmprc_pkg::C_BYTE_W-1:0]     i_data_byte,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [bmprc_pkg::C_COORD_W-1:0]    o_screen_x,
    output logic [bmprc_pkg::C_COORD_W-1:0]    o_screen_y,
    output logic [bmprc_pkg::C_COLOR_W-1:0]    o_pixel_color,
    output logic                               o_last_pixel
);
    import bmprc_pkg::*;

    // Raw configuration registers, as written.
    logic [C_DIM_W-1:0]   r_image_width;
    logic [C_DIM_W-1:0]   r_image_height;
    logic [C_ORG_W-1:0]   r_origin_x;
    logic [C_ORG_W-1:0]   r_origin_y;
    logic [C_MODE_W-1:0]  r_recolor_mode;
    logic [C_COLOR_W-1:0] r_match_color;
    logic [C_COLOR_W-1:0] r_replace_color;

    t_cfg    cfg;
    t_q_stat q_stat;
    logic    q_push;
    logic    q_pop;
    t_pixel  front_pixel;
    t_pixel  head_pixel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width   <= C_DIM_W'(1);
            r_image_height  <= C_DIM_W'(1);
            r_origin_x      <= '0;
            r_origin_y      <= '0;
            r_recolor_mode  <= '0;
            r_match_color   <= '0;
            r_replace_color <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_IMAGE_WIDTH:   r_image_width   <= i_cfg_data[C_DIM_W-1:0];
                CFG_IMAGE_HEIGHT:  r_image_height  <= i_cfg_data[C_DIM_W-1:0];
                CFG_ORIGIN_X:      r_origin_x      <= i_cfg_data[C_ORG_W-1:0];
                CFG_ORIGIN_Y:      r_origin_y      <= i_cfg_data[C_ORG_W-1:0];
                CFG_RECOLOR_MODE:  r_recolor_mode  <= i_cfg_data[C_MODE_W-1:0];
                CFG_MATCH_COLOR:   r_match_color   <= i_cfg_data[C_COLOR_W-1:0];
                CFG_REPLACE_COLOR: r_replace_color <= i_cfg_data[C_COLOR_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // The datapath sees the dimensions already clamped to their legal range.
    assign cfg.width         = clamp_dim(r_image_width);
    assign cfg.height        = clamp_dim(r_image_height);
    assign cfg.origin_x      = r_origin_x;
    assign cfg.origin_y      = r_origin_y;
    assign cfg.mode          = r_recolor_mode;
    assign cfg.match_color   = r_match_color;
    assign cfg.replace_color = r_replace_color;

    bmprc_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_byte_valid (i_in_valid),
        .i_byte       (i_data_byte),
        .i_q_stat     (q_stat),
        .o_byte_stall (o_in_stall),
        .o_push       (q_push),
        .o_pixel      (front_pixel)
    );

    bmprc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_pixel (front_pixel),
        .i_pop   (q_pop),
        .o_pixel (head_pixel),
        .o_stat  (q_stat)
    );

    bmprc_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_q_stat      (q_stat),
        .i_pixel       (head_pixel),
        .o_pop         (q_pop),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_screen_x    (o_screen_x),
        .o_screen_y    (o_screen_y),
        .o_pixel_color (o_pixel_color),
        .o_last_pixel  (o_last_pixel)
    );

endmodule
